FILE: hdl/body_pose_rotation_transform_assert.svh
// ----------------------------------------------------------------------------
// body_pose_rotation_transform_assert.svh - assertion macros
// Shared property forms for the body pose rotation block; clock is clk,
// reset is rst_n.
// ----------------------------------------------------------------------------
`ifndef BODY_POSE_ROTATION_TRANSFORM_ASSERT_SVH
`define BODY_POSE_ROTATION_TRANSFORM_ASSERT_SVH

// same-cycle or delayed implication
`define BPRT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// next-cycle implication
`define BPRT_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/bprt_pkg.sv
// ----------------------------------------------------------------------------
// bprt_pkg - body pose rotation shared types and constants
// Angle reduction, CORDIC arctangent table, rounding and saturation helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package bprt_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 15;
    localparam int MAX_STEPS = 24;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ROLL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PITCH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_YAW   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHY   = 3'd4;

    localparam logic signed [16:0] PI_U      = 17'sd12868;
    localparam logic signed [16:0] TWO_PI_U  = 17'sd25736;
    localparam logic signed [16:0] HALF_PI_U = 17'sd6434;
    localparam logic signed [31:0] GAIN_Q28  = 32'sd163008219;

    typedef struct packed {
        logic signed [13:0] ang;
        logic               neg;
    } ang_t;

    typedef struct packed {
        logic signed [12:0] tx;
        logic signed [12:0] ty;
        logic signed [11:0] z;
        logic signed [9:0]  shx;
        logic signed [9:0]  shy;
    } pos_t;

    typedef struct packed {
        pos_t pos;
        ang_t roll;
        ang_t pitch;
        ang_t yaw;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // wrap into +-pi, then fold into +-pi/2 with a sign flip flag
    function automatic ang_t reduce_angle(input logic signed [15:0] a);
        logic signed [16:0] w;
        ang_t r;
        w = {a[15], a};
        if (w > PI_U)
            w = w - TWO_PI_U;
        else if (w < -PI_U)
            w = w + TWO_PI_U;
        r.neg = 1'b0;
        if (w > HALF_PI_U)
        begin
            w = w - PI_U;
            r.neg = 1'b1;
        end
        else if (w < -HALF_PI_U)
        begin
            w = w + PI_U;
            r.neg = 1'b1;
        end
        r.ang = w[13:0];
        return r;
    endfunction

    // round(atan(2^-i) * 2^20)
    function automatic logic [19:0] atan_q20(input int i);
        case (i)
            0:  return 20'd823550;
            1:  return 20'd486170;
            2:  return 20'd256879;
            3:  return 20'd130396;
            4:  return 20'd65451;
            5:  return 20'd32757;
            6:  return 20'd16383;
            7:  return 20'd8192;
            8:  return 20'd4096;
            9:  return 20'd2048;
            10: return 20'd1024;
            11: return 20'd512;
            12: return 20'd256;
            13: return 20'd128;
            14: return 20'd64;
            15: return 20'd32;
            16: return 20'd16;
            17: return 20'd8;
            18: return 20'd4;
            19: return 20'd2;
            20: return 20'd1;
            default: return 20'd0;
        endcase
    endfunction

    // Q2.28 to Q1.14, round half up, clamp to +-1.0
    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
        logic signed [32:0] t;
        t = (v + 33'sd8192) >>> 14;
        if (t > 33'sd16384)
            return 16'sd16384;
        if (t < -33'sd16384)
            return -16'sd16384;
        return t[15:0];
    endfunction

    function automatic logic signed [13:0] sat_out(input logic signed [23:0] v);
        if (v > 24'sd8191)
            return 14'sd8191;
        if (v < -24'sd8192)
            return -14'sd8192;
        return v[13:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/bprt_front.sv
// ----------------------------------------------------------------------------
// bprt_front - command intake
// Accepts a foot point, forms the shifted point and reduces the three angles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bprt_front
(
    input  wire logic                    start,
    input  wire logic signed [11:0]      point_x,
    input  wire logic signed [11:0]      point_y,
    input  wire logic signed [11:0]      point_z,
    input  wire logic signed [9:0]       hip_offset_x,
    input  wire logic signed [9:0]       hip_offset_y,
    input  wire logic signed [14:0]      extra_yaw,
    input  wire logic signed [14:0]      body_roll,
    input  wire logic signed [14:0]      body_pitch,
    input  wire logic signed [14:0]      body_yaw,
    input  wire logic signed [9:0]       body_shift_x,
    input  wire logic signed [9:0]       body_shift_y,
    input  wire bprt_pkg::fifo_stat_t    stat,
    output logic                         push,
    output bprt_pkg::entry_t             entry
);

    logic signed [15:0] yaw_sum;

    // take a word whenever the queue has room
    assign push = start & ~stat.full;

    // combined yaw, exact
    assign yaw_sum = 16'(body_yaw) + 16'(extra_yaw);

    // shift the point and classify the angles
    always_comb
    begin
        entry.pos.tx  = 13'(point_x) + 13'(hip_offset_x) + 13'(body_shift_x);
        entry.pos.ty  = 13'(point_y) + 13'(hip_offset_y) + 13'(body_shift_y);
        entry.pos.z   = point_z;
        entry.pos.shx = body_shift_x;
        entry.pos.shy = body_shift_y;
        entry.roll    = bprt_pkg::reduce_angle(16'(body_roll));
        entry.pitch   = bprt_pkg::reduce_angle(16'(body_pitch));
        entry.yaw     = bprt_pkg::reduce_angle(yaw_sum);
    end

endmodule
`default_nettype wire

FILE: hdl/bprt_fifo.sv
// ----------------------------------------------------------------------------
// bprt_fifo - command queue
// Short queue between intake and datapath; drains one word a cycle while pop is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bprt_fifo
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  wire bprt_pkg::entry_t     wr_data,
    input  wire logic                 pop,
    output bprt_pkg::entry_t          rd_data,
    output bprt_pkg::fifo_stat_t      stat
);

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    bprt_pkg::entry_t     mem [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]       count_reg, count_next;

    assign stat.full  = (count_reg == (PTR_W+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !(pop && !stat.empty))
            count_next = count_reg + 1'b1;
        else if (!push && pop && !stat.empty)
            count_next = count_reg - 1'b1;
    end

    // store word
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop && !stat.empty)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/bprt_cordic.sv
// ----------------------------------------------------------------------------
// bprt_cordic - pipelined sine/cosine
// Rotation-mode CORDIC, one iteration per stage, Q1.14 outputs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bprt_cordic #(
    parameter int STEPS = 16
)
(
    input  wire logic               clk,
    input  wire bprt_pkg::ang_t     ang_in,
    output logic signed [15:0]      sin_q14,
    output logic signed [15:0]      cos_q14
);

    logic signed [31:0] xw [STEPS+1];
    logic signed [31:0] yw [STEPS+1];
    logic signed [23:0] zw [STEPS+1];
    logic               nw [STEPS+1];
    logic signed [31:0] x_reg [1:STEPS];
    logic signed [31:0] y_reg [1:STEPS];
    logic signed [23:0] z_reg [1:STEPS];
    logic               neg_reg [1:STEPS];
    logic signed [32:0] xo, yo;

    // start vector: gain-scaled unit x, angle in 2^-20 rad
    assign xw[0] = bprt_pkg::GAIN_Q28;
    assign yw[0] = '0;
    assign zw[0] = 24'($signed({ang_in.ang, 8'd0}));
    assign nw[0] = ang_in.neg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_iter
        localparam logic signed [23:0] ATAN = 24'(bprt_pkg::atan_q20(i));

        // rotate toward zero residual angle
        always_ff @(posedge clk)
        begin
            if (!zw[i][23])
            begin
                x_reg[i+1] <= xw[i] - (yw[i] >>> i);
                y_reg[i+1] <= yw[i] + (xw[i] >>> i);
                z_reg[i+1] <= zw[i] - ATAN;
            end
            else
            begin
                x_reg[i+1] <= xw[i] + (yw[i] >>> i);
                y_reg[i+1] <= yw[i] - (xw[i] >>> i);
                z_reg[i+1] <= zw[i] + ATAN;
            end
            neg_reg[i+1] <= nw[i];
        end

        assign xw[i+1] = x_reg[i+1];
        assign yw[i+1] = y_reg[i+1];
        assign zw[i+1] = z_reg[i+1];
        assign nw[i+1] = neg_reg[i+1];
    end

    // unfold and round
    assign xo = nw[STEPS] ? -33'(xw[STEPS]) : 33'(xw[STEPS]);
    assign yo = nw[STEPS] ? -33'(yw[STEPS]) : 33'(yw[STEPS]);

    always_ff @(posedge clk)
    begin
        cos_q14 <= bprt_pkg::to_q14(xo);
        sin_q14 <= bprt_pkg::to_q14(yo);
    end

endmodule
`default_nettype wire

FILE: hdl/bprt_back.sv
// ----------------------------------------------------------------------------
// bprt_back - rotation datapath
// Pops queued words, runs three CORDIC lanes and the rotation product tree.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module bprt_back #(
    parameter int STEPS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire bprt_pkg::fifo_stat_t  stat,
    input  wire bprt_pkg::entry_t      entry,
    output logic                       pop,
    output logic                       done,
    output logic signed [13:0]         delta_x,
    output logic signed [13:0]         delta_y,
    output logic signed [13:0]         delta_z
);

    localparam int VLD_LEN = STEPS + 8;

    bprt_pkg::entry_t   in_reg;
    bprt_pkg::pos_t     pos_reg [STEPS+1];
    bprt_pkg::pos_t     p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic [VLD_LEN-1:0] vld_reg;

    logic signed [15:0] sb, cb, sg, cg, sa, ca;

    // stage 1
    logic signed [31:0] sbsg_reg, cbsg_reg, sbcg_reg, cbcg_reg;
    logic signed [28:0] txcg1_reg, txsg1_reg, tycb_reg;
    logic signed [27:0] zsb_reg;
    logic signed [15:0] sa1_reg, ca1_reg;
    // stage 2
    logic signed [44:0] a1_reg, b1_reg;
    logic signed [43:0] a2_reg, b2_reg;
    logic signed [29:0] v2_reg;
    logic signed [28:0] txcg2_reg, txsg2_reg;
    logic signed [15:0] sa2_reg, ca2_reg;
    // stage 3
    logic signed [45:0] u_reg, w3_reg;
    logic signed [29:0] v3_reg;
    logic signed [15:0] sa3_reg, ca3_reg;
    // stage 4
    logic signed [22:0] u_hi;
    logic signed [23:0] u_lo;
    logic signed [38:0] pa_reg, pc_reg;
    logic signed [39:0] pb_reg, pd_reg;
    logic signed [45:0] vs_reg, vc_reg, w4_reg;
    // stage 5
    logic signed [61:0] sx_reg, sy_reg;
    logic signed [45:0] w5_reg;
    // stage 6
    logic signed [19:0] qx, qy;
    logic signed [17:0] qz;
    logic signed [23:0] dx, dy, dz;

    // drain the queue whenever it holds a word
    assign pop = ~stat.empty;

    always_ff @(posedge clk)
    begin
        in_reg <= entry;
    end

    bprt_cordic #(.STEPS(STEPS)) u_roll
    (
        .clk     (clk),
        .ang_in  (in_reg.roll),
        .sin_q14 (sb),
        .cos_q14 (cb)
    );

    bprt_cordic #(.STEPS(STEPS)) u_pitch
    (
        .clk     (clk),
        .ang_in  (in_reg.pitch),
        .sin_q14 (sg),
        .cos_q14 (cg)
    );

    bprt_cordic #(.STEPS(STEPS)) u_yaw
    (
        .clk     (clk),
        .ang_in  (in_reg.yaw),
        .sin_q14 (sa),
        .cos_q14 (ca)
    );

    // hold the point alongside the CORDIC lanes
    always_ff @(posedge clk)
    begin
        pos_reg[0] <= in_reg.pos;
        for (int k = 1; k <= STEPS; k++)
            pos_reg[k] <= pos_reg[k-1];
    end

    // stage 1: trig pair products
    always_ff @(posedge clk)
    begin
        sbsg_reg  <= sb * sg;
        cbsg_reg  <= cb * sg;
        sbcg_reg  <= sb * cg;
        cbcg_reg  <= cb * cg;
        txcg1_reg <= pos_reg[STEPS].tx * cg;
        txsg1_reg <= pos_reg[STEPS].tx * sg;
        tycb_reg  <= pos_reg[STEPS].ty * cb;
        zsb_reg   <= pos_reg[STEPS].z * sb;
        sa1_reg   <= sa;
        ca1_reg   <= ca;
        p1_reg    <= pos_reg[STEPS];
    end

    // stage 2: coordinate products
    always_ff @(posedge clk)
    begin
        a1_reg    <= p1_reg.ty * sbsg_reg;
        a2_reg    <= p1_reg.z * cbsg_reg;
        b1_reg    <= p1_reg.ty * sbcg_reg;
        b2_reg    <= p1_reg.z * cbcg_reg;
        v2_reg    <= 30'(zsb_reg) - 30'(tycb_reg);
        txcg2_reg <= txcg1_reg;
        txsg2_reg <= txsg1_reg;
        sa2_reg   <= sa1_reg;
        ca2_reg   <= ca1_reg;
        p2_reg    <= p1_reg;
    end

    // stage 3: roll/pitch rotated sums
    always_ff @(posedge clk)
    begin
        u_reg   <= (46'(txcg2_reg) <<< 14) + 46'(a1_reg) + 46'(a2_reg);
        w3_reg  <= 46'(b1_reg) + 46'(b2_reg) - (46'(txsg2_reg) <<< 14);
        v3_reg  <= v2_reg;
        sa3_reg <= sa2_reg;
        ca3_reg <= ca2_reg;
        p3_reg  <= p2_reg;
    end

    // stage 4: yaw partial products, u split in two halves
    assign u_hi = $signed(u_reg[45:23]);
    assign u_lo = $signed({1'b0, u_reg[22:0]});

    always_ff @(posedge clk)
    begin
        pa_reg <= ca3_reg * u_hi;
        pb_reg <= ca3_reg * u_lo;
        pc_reg <= sa3_reg * u_hi;
        pd_reg <= sa3_reg * u_lo;
        vs_reg <= sa3_reg * v3_reg;
        vc_reg <= ca3_reg * v3_reg;
        w4_reg <= w3_reg;
        p4_reg <= p3_reg;
    end

    // stage 5: combine partial products
    always_ff @(posedge clk)
    begin
        sx_reg <= (62'(pa_reg) <<< 23) + 62'(pb_reg) + (62'(vs_reg) <<< 14);
        sy_reg <= (62'(pc_reg) <<< 23) + 62'(pd_reg) - (62'(vc_reg) <<< 14);
        w5_reg <= w4_reg;
        p5_reg <= p4_reg;
    end

    // stage 6: truncate toward zero, difference, saturate
    always_comb
    begin
        qx = $signed(sx_reg[61:42]) + 20'(sx_reg[61] && (sx_reg[41:0] != '0));
        qy = $signed(sy_reg[61:42]) + 20'(sy_reg[61] && (sy_reg[41:0] != '0));
        qz = $signed(w5_reg[45:28]) + 18'(w5_reg[45] && (w5_reg[27:0] != '0));
        dx = 24'(p5_reg.tx) + 24'(p5_reg.shx) - 24'(qx);
        dy = 24'(p5_reg.ty) + 24'(p5_reg.shy) - 24'(qy);
        dz = 24'(p5_reg.z) - 24'(qz);
    end

    always_ff @(posedge clk)
    begin
        delta_x <= bprt_pkg::sat_out(dx);
        delta_y <= bprt_pkg::sat_out(dy);
        delta_z <= bprt_pkg::sat_out(dz);
    end

    // track valid words down the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[VLD_LEN-2:0], pop};
    end

    assign done = vld_reg[VLD_LEN-1];

endmodule
`default_nettype wire

FILE: hdl/body_pose_rotation_transform.sv
// ----------------------------------------------------------------------------
// body_pose_rotation_transform - body pose foot correction
// Rotates a shifted foot point by body roll, pitch and yaw and returns the
// saturated correction on x, y and z.
// ----------------------------------------------------------------------------
// One point is taken per clock: a command is accepted when start is high and
// busy is low, and its result appears on delta_x/y/z with done high for one
// cycle. The command is queued, then passes through the three CORDIC lanes,
// one iteration per stage, followed by six product and rounding stages.
// Results cannot be held off; capture them in the done cycle. Registers are
// written with cfg_we/cfg_index/cfg_data and should only change while no
// command is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "body_pose_rotation_transform_assert.svh"
module body_pose_rotation_transform #(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic signed [11:0]                  point_x,
    input  wire logic signed [11:0]                  point_y,
    input  wire logic signed [11:0]                  point_z,
    input  wire logic signed [9:0]                   hip_offset_x,
    input  wire logic signed [9:0]                   hip_offset_y,
    input  wire logic signed [14:0]                  extra_yaw,
    output logic                                     done,
    output logic signed [13:0]                       delta_x,
    output logic signed [13:0]                       delta_y,
    output logic signed [13:0]                       delta_z,
    input  wire logic                                cfg_we,
    input  wire logic [bprt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [bprt_pkg::CFG_DAT_W-1:0]      cfg_data
);

    localparam int STEPS = (CORDIC_STEPS > bprt_pkg::MAX_STEPS) ?
                           bprt_pkg::MAX_STEPS : CORDIC_STEPS;
    localparam int LAT   = STEPS + 9;

    logic signed [14:0]    roll_reg, pitch_reg, yaw_reg;
    logic signed [9:0]     shx_reg, shy_reg;
    logic                  push, pop;
    bprt_pkg::entry_t      wr_entry, rd_entry;
    bprt_pkg::fifo_stat_t  stat;

    // register writes, unknown index dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_reg  <= '0;
            pitch_reg <= '0;
            yaw_reg   <= '0;
            shx_reg   <= '0;
            shy_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bprt_pkg::REG_ROLL:  roll_reg  <= cfg_data;
                bprt_pkg::REG_PITCH: pitch_reg <= cfg_data;
                bprt_pkg::REG_YAW:   yaw_reg   <= cfg_data;
                bprt_pkg::REG_SHX:   shx_reg   <= cfg_data[9:0];
                bprt_pkg::REG_SHY:   shy_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    bprt_front u_front
    (
        .start        (start),
        .point_x      (point_x),
        .point_y      (point_y),
        .point_z      (point_z),
        .hip_offset_x (hip_offset_x),
        .hip_offset_y (hip_offset_y),
        .extra_yaw    (extra_yaw),
        .body_roll    (roll_reg),
        .body_pitch   (pitch_reg),
        .body_yaw     (yaw_reg),
        .body_shift_x (shx_reg),
        .body_shift_y (shy_reg),
        .stat         (stat),
        .push         (push),
        .entry        (wr_entry)
    );

    bprt_fifo u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_entry),
        .pop     (pop),
        .rd_data (rd_entry),
        .stat    (stat)
    );

    bprt_back #(.STEPS(STEPS)) u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .stat    (stat),
        .entry   (rd_entry),
        .pop     (pop),
        .done    (done),
        .delta_x (delta_x),
        .delta_y (delta_y),
        .delta_z (delta_z)
    );

    assign busy = stat.full;

    `BPRT_ASSERT_IMP(a_lat_done, start && !busy, ##LAT done, "accepted word lost")
    `BPRT_ASSERT_IMP(a_lat_idle, !(start && !busy), ##LAT !done, "result without command")
    `BPRT_ASSERT_NXT(a_queued, start && !busy, !stat.empty, "accepted word not queued")

endmodule
`default_nettype wire
